### hw/rtl/cubic_bspline_evaluator_unit_defines.svh
// ----------------------------------------------------------------------------
// cubic b-spline evaluator assertion macros
// concurrent checks clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CUBIC_BSPLINE_EVALUATOR_UNIT_DEFINES_SVH
`define CUBIC_BSPLINE_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// types, constants and fixed-point helpers of the cubic b-spline evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbs_pkg;

  localparam int COORD_W  = 16;
  localparam int T_W      = 17;
  localparam int IDX_W    = 4;
  localparam int PC_W     = 5;
  localparam int OUT_W    = 24;
  localparam int GUARD    = 16;
  localparam int COEF_W   = COORD_W + 6;
  localparam int ACC_W    = COORD_W + 23;
  localparam int PROD_W   = ACC_W + T_W + 1;
  localparam int DIVW_W   = ACC_W - (GUARD + 1);
  localparam int DIV_N    = DIVW_W + 1;
  localparam int RECIP    = (2 ** (DIV_N + 1) + 2) / 3;
  localparam int OUT_MAX  = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN  = -(2 ** (OUT_W - 1));
  localparam int FIFO_DEPTH = 2;
  localparam int REG_POINT_COUNT = 0;
  localparam logic [PC_W-1:0] PC_RESET = PC_W'(4);
  localparam logic [T_W-1:0]  T_ONE    = T_W'(65536);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [OUT_W-1:0]   out_t;
  typedef logic [DIV_N-1:0]          quot_t;

  typedef struct packed {
    logic             op;
    logic             err;
    logic [IDX_W-1:0] idx;
    logic [T_W-1:0]   t;
    coord_t           x;
    coord_t           y;
    coord_t           z;
  } cmd_t;

  typedef struct packed {
    coef_t a3;
    coef_t a2;
    coef_t a1;
    coef_t a0;
  } coefs_t;

  typedef struct packed {
    out_t [2:0] pos;
    out_t [2:0] tan;
    out_t [2:0] acc;
    logic       err;
  } res_t;

  function automatic coefs_t make_coefs(coord_t p0, coord_t p1, coord_t p2, coord_t p3);
    coefs_t c;
    coef_t  q0, q1, q2, q3;
    q0 = COEF_W'(p0);
    q1 = COEF_W'(p1);
    q2 = COEF_W'(p2);
    q3 = COEF_W'(p3);
    c.a3 = COEF_W'(-q0 + 3 * q1 - 3 * q2 + q3);
    c.a2 = COEF_W'(3 * q0 - 6 * q1 + 3 * q2);
    c.a1 = COEF_W'(3 * (q2 - q0));
    c.a0 = COEF_W'(q0 + 4 * q1 + q2);
    return c;
  endfunction

  // coefficient moved onto the guard bits
  function automatic acc_t lead(coef_t c);
    return ACC_W'(c) <<< GUARD;
  endfunction

  // acc * t rounded half up to the guard bits, plus next coefficient
  function automatic acc_t horner_step(acc_t src, logic [T_W-1:0] t, coef_t c);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    prod = PROD_W'(src) * $signed({1'b0, t});
    rnd  = prod + (PROD_W'(1) <<< (GUARD - 1));
    return ACC_W'(rnd >>> GUARD) + lead(c);
  endfunction

  // offset floor(y / 2^17) so that a divide by three works on unsigned bits
  function automatic quot_t div_operand(acc_t v);
    acc_t                      y;
    logic signed [DIVW_W-1:0]  w;
    y = v + ACC_W'(3 * (2 ** GUARD));
    w = DIVW_W'(y >>> (GUARD + 1));
    return quot_t'(DIV_N'(w) + DIV_N'(3 * (2 ** (DIVW_W - 1))));
  endfunction

  function automatic out_t finish(quot_t q);
    logic signed [DIV_N+1:0] s;
    s = $signed({2'b00, q}) - (DIV_N + 2)'(2 ** (DIVW_W - 1));
    if (s > OUT_MAX) begin
      return out_t'(OUT_MAX);
    end else if (s < OUT_MIN) begin
      return out_t'(OUT_MIN);
    end
    return OUT_W'(s);
  endfunction

endpackage

### hw/rtl/cbs_front.sv
// ----------------------------------------------------------------------------
// cbs_front
// register port and word classification: range check, t clamp, load filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbs_front #(
  parameter int MAX_POINTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [0:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_op,
  input  logic [cbs_pkg::IDX_W-1:0]   in_point_index,
  input  cbs_pkg::coord_t             in_point_x,
  input  cbs_pkg::coord_t             in_point_y,
  input  cbs_pkg::coord_t             in_point_z,
  input  logic [cbs_pkg::IDX_W-1:0]   in_segment,
  input  logic [cbs_pkg::T_W-1:0]     in_param_t,
  input  logic                        fifo_full,
  output logic                        fifo_push,
  output cbs_pkg::cmd_t               fifo_cmd
);
  import cbs_pkg::*;

  logic [PC_W-1:0] point_count_r;
  logic [PC_W-1:0] point_count_nxt;
  logic            reg_wr;
  logic            drop;
  logic [PC_W:0]   seg_top;

  assign pready = 1'b1;
  assign prdata = 32'(point_count_r);
  assign reg_wr = psel && penable && pwrite && ((32'(paddr) >> 2) == REG_POINT_COUNT);

  always_comb begin
    point_count_nxt = point_count_r;
    if (reg_wr) begin
      point_count_nxt = pwdata[PC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= PC_RESET;
    end else begin
      point_count_r <= point_count_nxt;
    end
  end

  assign seg_top = (PC_W + 1)'(in_segment) + (PC_W + 1)'(3);
  assign drop    = (in_op == OP_LOAD) && (int'(in_point_index) >= MAX_POINTS);

  always_comb begin
    fifo_cmd.op  = in_op;
    fifo_cmd.err = (seg_top >= (PC_W + 1)'(point_count_r)) || (int'(seg_top) >= MAX_POINTS);
    fifo_cmd.idx = (in_op == OP_EVAL) ? in_segment : in_point_index;
    fifo_cmd.t   = (in_param_t > T_ONE) ? T_ONE : in_param_t;
    fifo_cmd.x   = in_point_x;
    fifo_cmd.y   = in_point_y;
    fifo_cmd.z   = in_point_z;
  end

  assign in_full   = fifo_full;
  assign fifo_push = in_push && !fifo_full && !drop;

endmodule

### hw/rtl/cbs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// cbs_cmd_fifo
// short word queue between the front and the evaluation back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cubic_bspline_evaluator_unit_defines.svh"

module cbs_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cbs_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output cbs_pkg::cmd_t pop_cmd
);
  import cbs_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == (PTR_W + 1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `CBS_ASSERT_NOW(a_fifo_count, 1'b1, count_r <= (PTR_W + 1)'(FIFO_DEPTH), "fifo count overflow")
  `CBS_ASSERT_NOW(a_fifo_push, push, !full, "push while full")
  `CBS_ASSERT_NEXT(a_fifo_grow, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "count lost")

endmodule

### hw/rtl/cbs_back.sv
// ----------------------------------------------------------------------------
// cbs_back
// point store, basis weighting by horner steps per axis, rounding and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cubic_bspline_evaluator_unit_defines.svh"

module cbs_back #(
  parameter int MAX_POINTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  cbs_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_pop,
  output cbs_pkg::res_t res
);
  import cbs_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_COEF = 5'b00100,
    S_EVAL = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;
  logic                 take_err;
  logic [IDX_W-1:0]     seg_r;
  logic [T_W-1:0]       t_r;
  logic [3*COORD_W-1:0] mem_r [MAX_POINTS];
  logic [3*COORD_W-1:0] rd_r;
  logic [AW-1:0]        rd_addr;
  coord_t               pt_r [3][4];
  coefs_t               coef_r [3];
  acc_t                 pa_r [3];
  acc_t                 ta_r [3];
  acc_t                 aa_r [3];
  quot_t                dq_r [3];
  acc_t                 step_res [3];
  quot_t                dq_nxt [3];
  res_t                 res_r;

  assign slot_free = !out_valid_r || out_pop;
  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign rd_addr   = AW'(seg_r) + AW'(cnt_r);
  assign take_err  = (state_r == S_IDLE) && cmd_valid && (cmd.op == OP_EVAL) && cmd.err
                     && slot_free;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_pop       = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_LOAD) begin
            cmd_pop = 1'b1;
          end else if (cmd.err) begin
            if (slot_free) begin
              cmd_pop       = 1'b1;
              out_valid_nxt = 1'b1;
            end
          end else begin
            cmd_pop   = 1'b1;
            state_nxt = S_READ;
            cnt_nxt   = '0;
          end
        end
      end
      S_READ: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = S_COEF;
        end
      end
      S_COEF: begin
        state_nxt = S_EVAL;
        cnt_nxt   = '0;
      end
      S_EVAL: begin
        if (cnt_r != 3'd5) begin
          cnt_nxt = cnt_r + 3'd1;
        end else if (slot_free) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // point store, one port
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid && cmd.op == OP_LOAD) begin
      mem_r[AW'(cmd.idx)] <= {cmd.x, cmd.y, cmd.z};
    end else if (state_r == S_READ && cnt_r < 3'd4) begin
      rd_r <= mem_r[rd_addr];
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      unique case (cnt_r)
        3'd0:    step_res[l] = horner_step(lead(coef_r[l].a3), t_r, coef_r[l].a2);
        3'd1:    step_res[l] = horner_step(pa_r[l], t_r, coef_r[l].a1);
        3'd2:    step_res[l] = horner_step(pa_r[l], t_r, coef_r[l].a0);
        3'd3:    step_res[l] = horner_step(lead(COEF_W'(3 * coef_r[l].a3)), t_r,
                                           COEF_W'(2 * coef_r[l].a2));
        3'd4:    step_res[l] = horner_step(ta_r[l], t_r, coef_r[l].a1);
        default: step_res[l] = horner_step(lead(COEF_W'(6 * coef_r[l].a3)), t_r,
                                           COEF_W'(2 * coef_r[l].a2));
      endcase
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [2*DIV_N-1:0] prod;
      quot_t              u;
      unique case (cnt_r)
        3'd0:    u = div_operand(pa_r[l]);
        3'd1:    u = div_operand(ta_r[l]);
        default: u = div_operand(aa_r[l]);
      endcase
      prod      = (2 * DIV_N)'(u) * (2 * DIV_N)'(RECIP);
      dq_nxt[l] = DIV_N'(prod >> (DIV_N + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_pop && cmd.op == OP_EVAL) begin
      seg_r <= cmd.idx;
      t_r   <= cmd.t;
    end
    // zero vectors with the error flag set
    if (take_err) begin
      res_r <= res_t'(1'b1);
    end
    if (state_r == S_READ && cnt_r != 3'd0) begin
      for (int l = 0; l < 3; l++) begin
        pt_r[l][3] <= rd_r[(2 - l) * COORD_W +: COORD_W];
        for (int k = 0; k < 3; k++) begin
          pt_r[l][k] <= pt_r[l][k + 1];
        end
      end
    end
    if (state_r == S_COEF) begin
      for (int l = 0; l < 3; l++) begin
        coef_r[l] <= make_coefs(pt_r[l][0], pt_r[l][1], pt_r[l][2], pt_r[l][3]);
      end
    end
    if (state_r == S_EVAL) begin
      for (int l = 0; l < 3; l++) begin
        if (cnt_r <= 3'd2) begin
          pa_r[l] <= step_res[l];
        end else if (cnt_r <= 3'd4) begin
          ta_r[l] <= step_res[l];
        end else begin
          aa_r[l] <= step_res[l];
        end
      end
    end
    if (state_r == S_DIV) begin
      for (int l = 0; l < 3; l++) begin
        if (cnt_r != 3'd3) begin
          dq_r[l] <= dq_nxt[l];
        end
        unique case (cnt_r)
          3'd1:    res_r.pos[l] <= finish(dq_r[l]);
          3'd2:    res_r.tan[l] <= finish(dq_r[l]);
          3'd3:    res_r.acc[l] <= finish(dq_r[l]);
          default: ;
        endcase
      end
      res_r.err <= 1'b0;
    end
  end

  `CBS_ASSERT_NOW(a_div_slot, state_r == S_DIV, !out_valid_r, "result slot busy during rounding")
  `CBS_ASSERT_NOW(a_err_zero, out_valid_r && res_r.err, res_r.pos[0] == '0 && res_r.acc[2] == '0,
                  "range error with nonzero result")
  `CBS_ASSERT_NEXT(a_eval_start, state_r == S_IDLE && cmd_pop && cmd.op == OP_EVAL && !cmd.err,
                   state_r == S_READ, "evaluation did not start")

endmodule

### hw/rtl/cubic_bspline_evaluator_unit.sv
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator_unit
// uniform cubic b-spline position, tangent and second derivative evaluator
// ----------------------------------------------------------------------------
// Words enter through a two-entry queue, so the input side keeps accepting
// while the back end works. A load word writes its point; a load to a slot
// beyond the store is dropped. An evaluate word passes a start state, reads
// the four points through the single-port point store, forms the basis
// coefficients, runs six horner steps on one multiplier per axis, waits
// while the output register is full, and rounds and divides by six. An
// evaluate with an out-of-range segment returns zeros with range_error set
// once the output register is free. A finished result waits there until popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_bspline_evaluator_unit #(
  parameter int MAX_POINTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [0:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_op,
  input  logic [cbs_pkg::IDX_W-1:0]   in_point_index,
  input  cbs_pkg::coord_t             in_point_x,
  input  cbs_pkg::coord_t             in_point_y,
  input  cbs_pkg::coord_t             in_point_z,
  input  logic [cbs_pkg::IDX_W-1:0]   in_segment,
  input  logic [cbs_pkg::T_W-1:0]     in_param_t,
  output logic                        out_empty,
  input  logic                        out_pop,
  output cbs_pkg::out_t               out_pos_x,
  output cbs_pkg::out_t               out_pos_y,
  output cbs_pkg::out_t               out_pos_z,
  output cbs_pkg::out_t               out_tan_x,
  output cbs_pkg::out_t               out_tan_y,
  output cbs_pkg::out_t               out_tan_z,
  output cbs_pkg::out_t               out_acc_x,
  output cbs_pkg::out_t               out_acc_y,
  output cbs_pkg::out_t               out_acc_z,
  output logic                        out_range_error
);
  import cbs_pkg::*;

  logic fifo_full, fifo_push, fifo_not_empty, fifo_pop, out_valid;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  cbs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_push, .in_full, .in_op, .in_point_index, .in_point_x, .in_point_y,
    .in_point_z, .in_segment, .in_param_t,
    .fifo_full, .fifo_push, .fifo_cmd(push_cmd)
  );

  cbs_cmd_fifo u_fifo (
    .clk, .rst_n, .push(fifo_push), .push_cmd, .full(fifo_full),
    .not_empty(fifo_not_empty), .pop(fifo_pop), .pop_cmd
  );

  cbs_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk, .rst_n, .cmd_valid(fifo_not_empty), .cmd(pop_cmd), .cmd_pop(fifo_pop),
    .out_valid, .out_pop, .res
  );

  assign out_empty       = !out_valid;
  assign out_pos_x       = res.pos[0];
  assign out_pos_y       = res.pos[1];
  assign out_pos_z       = res.pos[2];
  assign out_tan_x       = res.tan[0];
  assign out_tan_y       = res.tan[1];
  assign out_tan_z       = res.tan[2];
  assign out_acc_x       = res.acc[0];
  assign out_acc_y       = res.acc[1];
  assign out_acc_z       = res.acc[2];
  assign out_range_error = res.err;

endmodule

### dv/cubic_bspline_evaluator_unit_test.sv
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator_unit_test
// loads control points and evaluates segments, both queue sides idle at random;
// a scoreboard predicts position, tangent and second derivative for every evaluate word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_bspline_evaluator_unit_test;
  import cbs_pkg::*;

  typedef struct {
    logic             op;
    logic [IDX_W-1:0] idx;
    coord_t           x;
    coord_t           y;
    coord_t           z;
    logic [IDX_W-1:0] seg;
    logic [T_W-1:0]   t;
  } word_t;

  typedef struct {
    out_t pos [3];
    out_t tan [3];
    out_t acc [3];
    logic err;
  } curve_t;

  class curve_scoreboard;
    longint           points [16][3];
    logic [PC_W-1:0]  count;
    curve_t           pending [$];
    int               fails;

    function new();
      count = PC_RESET;
      fails = 0;
    endfunction

    function longint rdiv(longint x, longint d);
      longint y;
      longint q;
      y = x + d / 2;
      q = y / d;
      if ((y % d) != 0 && y < 0) q--;
      return q;
    endfunction

    function longint hstep(longint a, longint t, longint c);
      return rdiv(a * t, 65536) + c * 65536;
    endfunction

    function out_t clamp(longint v);
      if (v > OUT_MAX) v = OUT_MAX;
      if (v < OUT_MIN) v = OUT_MIN;
      return out_t'(v);
    endfunction

    function void note(word_t w);
      curve_t r;
      longint t, p0, p1, p2, p3, a3, a2, a1, a0, a;
      if (w.op == OP_LOAD) begin
        points[w.idx][0] = longint'(w.x);
        points[w.idx][1] = longint'(w.y);
        points[w.idx][2] = longint'(w.z);
        return;
      end
      t = (w.t > 65536) ? 65536 : w.t;
      r.err = (w.seg + 3 >= count) || (w.seg + 3 >= 16);
      for (int c = 0; c < 3; c++) begin
        r.pos[c] = '0;
        r.tan[c] = '0;
        r.acc[c] = '0;
        if (!r.err) begin
          p0 = points[w.seg][c];
          p1 = points[w.seg + 1][c];
          p2 = points[w.seg + 2][c];
          p3 = points[w.seg + 3][c];
          a3 = -p0 + 3 * p1 - 3 * p2 + p3;
          a2 = 3 * p0 - 6 * p1 + 3 * p2;
          a1 = -3 * p0 + 3 * p2;
          a0 = p0 + 4 * p1 + p2;
          a = hstep(hstep(hstep(a3 * 65536, t, a2), t, a1), t, a0);
          r.pos[c] = clamp(rdiv(a, 6 * 65536));
          a = hstep(hstep(3 * a3 * 65536, t, 2 * a2), t, a1);
          r.tan[c] = clamp(rdiv(a, 6 * 65536));
          a = hstep(6 * a3 * 65536, t, 2 * a2);
          r.acc[c] = clamp(rdiv(a, 6 * 65536));
        end
      end
      pending = {pending, r};
    endfunction

    function void cmp(string name, out_t e, out_t a);
      if (e !== a) begin
        $error("%s expected %0d actual %0d", name, e, a);
        fails++;
      end
    endfunction

    function void check(curve_t a);
      curve_t e;
      if (pending.size() == 0) begin
        $error("result word with no expectation");
        fails++;
        return;
      end
      e = pending.pop_front();
      cmp("pos_x", e.pos[0], a.pos[0]);
      cmp("pos_y", e.pos[1], a.pos[1]);
      cmp("pos_z", e.pos[2], a.pos[2]);
      cmp("tan_x", e.tan[0], a.tan[0]);
      cmp("tan_y", e.tan[1], a.tan[1]);
      cmp("tan_z", e.tan[2], a.tan[2]);
      cmp("acc_x", e.acc[0], a.acc[0]);
      cmp("acc_y", e.acc[1], a.acc[1]);
      cmp("acc_z", e.acc[2], a.acc[2]);
      if (e.err !== a.err) begin
        $error("range_error expected %0d actual %0d", e.err, a.err);
        fails++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [0:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_push = 1'b0;
  logic             in_full;
  logic             in_op = OP_LOAD;
  logic [IDX_W-1:0] in_point_index = '0;
  coord_t           in_point_x = '0;
  coord_t           in_point_y = '0;
  coord_t           in_point_z = '0;
  logic [IDX_W-1:0] in_segment = '0;
  logic [T_W-1:0]   in_param_t = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  out_t             out_pos_x, out_pos_y, out_pos_z;
  out_t             out_tan_x, out_tan_y, out_tan_z;
  out_t             out_acc_x, out_acc_y, out_acc_z;
  logic             out_range_error;

  curve_scoreboard  sb = new();
  int               pop_mode = 0;
  int               pop_cnt = 0;

  always #5 clk = ~clk;

  cubic_bspline_evaluator_unit i_dut (.*);

  // accepted words on both sides
  always @(posedge clk) begin
    word_t  w;
    curve_t r;
    if (rst_n && in_push && !in_full) begin
      w.op = in_op;
      w.idx = in_point_index;
      w.x = in_point_x;
      w.y = in_point_y;
      w.z = in_point_z;
      w.seg = in_segment;
      w.t = in_param_t;
      sb.note(w);
    end
    if (rst_n && out_pop && !out_empty) begin
      r.pos = '{out_pos_x, out_pos_y, out_pos_z};
      r.tan = '{out_tan_x, out_tan_y, out_tan_z};
      r.acc = '{out_acc_x, out_acc_y, out_acc_z};
      r.err = out_range_error;
      sb.check(r);
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    pop_cnt <= pop_cnt + 1;
    if (pop_cnt % 256 == 0) pop_mode <= $urandom_range(3);
    case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= 1'($urandom_range(1));
      2: out_pop <= ($urandom_range(7) == 0);
      default: out_pop <= pop_cnt[4];
    endcase
  end

  task automatic push_word(word_t w);
    in_push <= 1'b1;
    in_op <= w.op;
    in_point_index <= w.idx;
    in_point_x <= w.x;
    in_point_y <= w.y;
    in_point_z <= w.z;
    in_segment <= w.seg;
    in_param_t <= w.t;
    do @(posedge clk); while (in_full);
  endtask

  task automatic load_point(int idx, coord_t x, coord_t y, coord_t z);
    word_t w;
    w.op = OP_LOAD;
    w.idx = IDX_W'(idx);
    w.x = x;
    w.y = y;
    w.z = z;
    w.seg = IDX_W'($urandom);
    w.t = T_W'($urandom);
    push_word(w);
  endtask

  task automatic evaluate(int seg, int t);
    word_t w;
    w.op = OP_EVAL;
    w.idx = IDX_W'($urandom);
    w.x = coord_t'($urandom);
    w.y = coord_t'($urandom);
    w.z = coord_t'($urandom);
    w.seg = IDX_W'(seg);
    w.t = T_W'(t);
    push_word(w);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_point_count(logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 1'(4 * REG_POINT_COUNT);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.count = v[PC_W-1:0];
  endtask

  function automatic int pick_t();
    case ($urandom_range(9))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(131071);
      default: return $urandom_range(65536);
    endcase
  endfunction

  task automatic random_phase(int n);
    int burst;
    int gap;
    int left;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && left > 0; i++, left--) begin
        if ($urandom_range(9) < 3) begin
          load_point($urandom_range(15), coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom));
        end else if ($urandom_range(3) == 0) begin
          evaluate($urandom_range(15), pick_t());
        end else begin
          evaluate($urandom_range(12), pick_t());
        end
      end
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_point(0, 16'sh7fff, 16'sh8000, 16'sh0000);
    load_point(1, 16'sh8000, 16'sh7fff, 16'shffff);
    load_point(2, 16'sh7fff, 16'sh8000, 16'sh0001);
    load_point(3, 16'sh8000, 16'sh7fff, 16'sh0100);
    for (int i = 4; i < 16; i++) begin
      load_point(i, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    end
    evaluate(0, 0);
    evaluate(0, 65536);
    evaluate(0, 131071);
    evaluate(1, 32768);
    drain();
    set_point_count(16);
    evaluate(12, 65536);
    evaluate(12, 1);
    evaluate(13, 100);
    evaluate(15, 65537);
    evaluate(0, 32768);
    drain();
    set_point_count(0);
    evaluate(0, 0);
    drain();
    set_point_count(32'hffff_ffe0 | 32'd16);
    random_phase(300);
    drain();
    set_point_count(31);
    random_phase(250);
    drain();
    set_point_count(4);
    random_phase(150);
    drain();
    set_point_count($urandom_range(5, 15) | 32'hffff_ffc0);
    random_phase(250);
    drain();
    set_point_count(16);
    random_phase(300);
    drain();
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("cubic_bspline_evaluator_unit test passed");
    end else begin
      $display("cubic_bspline_evaluator_unit test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("cubic_bspline_evaluator_unit test failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cbs_pkg.sv
hw/rtl/cbs_front.sv
hw/rtl/cbs_cmd_fifo.sv
hw/rtl/cbs_back.sv
hw/rtl/cubic_bspline_evaluator_unit.sv
dv/cubic_bspline_evaluator_unit_test.sv
